@@ rtl/acr_pkg.sv @@
// ----------------------------------------------------------------------------
// acr_pkg
// Shared constants and helpers for the associative cache replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package acr_pkg;

    localparam int LFSR_W = 16;
    localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
    localparam logic [LFSR_W-1:0] SEED_RESET = 16'hACE1;

    localparam int KEY_W    = 32;
    localparam int WAY_W    = 6;
    localparam int POLICY_W = 2;
    localparam int CFG_W    = 16;
    localparam int CFG_A_W  = 1;

    // policy codes
    localparam logic [POLICY_W-1:0] POL_LRU  = 2'd0;
    localparam logic [POLICY_W-1:0] POL_FIFO = 2'd1;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_POLICY = 1'd0;
    localparam logic [CFG_A_W-1:0] REG_SEED   = 1'd1;

    // galois lfsr, one step
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] s;
        begin
            s = v >> 1;
            if (v[0])
            begin
                s = s ^ LFSR_TAPS;
            end
            return s;
        end
    endfunction

    // a zero seed would lock the lfsr
    function automatic logic [LFSR_W-1:0] seed_load(input logic [LFSR_W-1:0] s);
        begin
            return (s == '0) ? {{(LFSR_W-1){1'b0}}, 1'b1} : s;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/assoc_cache_replacement.sv @@
// ----------------------------------------------------------------------------
// assoc_cache_replacement
// Fully associative key cache with LRU, FIFO or random replacement.
// ----------------------------------------------------------------------------
// One request is taken at a time; s_axis_tready is high only while the block
// is idle. A request sweeps the key and age memories one way per cycle; a miss
// then passes through the fetch and write states, and under LRU a second sweep
// rewrites every age. A random eviction with no empty way also waits for the
// remainder of the lfsr by ENTRIES. The result is held in an output register,
// so a new request can be taken while the previous result waits; a finished
// request stalls only while that register still holds an untaken result.
`default_nettype none

module assoc_cache_replacement #(
    parameter int ENTRIES  = 4,
    parameter int AGE_BITS = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // request: key[31:0]
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [31:0]                 s_axis_tdata,
    // result: hit[0], way[6:1], evicted_valid[7], evicted_key[39:8]
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [39:0]                 m_axis_tdata,
    input  wire logic                        cfg_we,
    input  wire logic [acr_pkg::CFG_A_W-1:0] cfg_addr,
    input  wire logic [acr_pkg::CFG_W-1:0]   cfg_data
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_MOD    = 3'd3;
    localparam logic [2:0] ST_FETCH  = 3'd4;
    localparam logic [2:0] ST_WRITE  = 3'd5;
    localparam logic [2:0] ST_AGE    = 3'd6;
    localparam logic [2:0] ST_FINISH = 3'd7;

    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    logic [2:0]                     state_reg;
    logic [CW-1:0]                  cnt_reg;
    logic                           rd_pend_reg;
    logic [IW-1:0]                  rd_idx_reg;
    logic [acr_pkg::KEY_W-1:0]      key_reg;
    logic                           hit_found_reg;
    logic [IW-1:0]                  hit_idx_reg;
    logic                           empty_found_reg;
    logic [IW-1:0]                  empty_idx_reg;
    logic [AGE_BITS-1:0]            best_age_reg;
    logic [IW-1:0]                  best_idx_reg;
    logic [IW-1:0]                  victim_reg;
    logic [IW-1:0]                  fifo_reg;
    logic [acr_pkg::LFSR_W-1:0]     lfsr_reg;
    logic [acr_pkg::POLICY_W-1:0]   policy_reg;
    logic [ENTRIES-1:0]             valid_reg;
    logic [ENTRIES-1:0]             age_ok_reg;
    logic                           ev_valid_reg;
    logic [acr_pkg::KEY_W-1:0]      ev_key_reg;

    logic                           out_valid_reg;
    logic                           out_hit_reg;
    logic [acr_pkg::WAY_W-1:0]      out_way_reg;
    logic                           out_ev_valid_reg;
    logic [acr_pkg::KEY_W-1:0]      out_ev_key_reg;

    logic [acr_pkg::KEY_W-1:0]      key_rdata;
    logic [AGE_BITS-1:0]            age_rdata;
    logic                           key_we;
    logic [IW-1:0]                  key_raddr;
    logic                           age_we;
    logic [AGE_BITS-1:0]            age_wdata;
    logic [AGE_BITS-1:0]            age_eff;
    logic                           sweep_issue;
    logic                           mod_start;
    logic                           mod_done;
    logic [IW-1:0]                  mod_rem;
    logic [acr_pkg::LFSR_W-1:0]     lfsr_stepped;
    logic [IW-1:0]                  fifo_victim;
    logic                           pol_lru;
    logic                           pol_fifo;
    logic                           out_free;

    assign pol_lru  = (policy_reg == acr_pkg::POL_LRU);
    assign pol_fifo = (policy_reg == acr_pkg::POL_FIFO);

    assign sweep_issue = (cnt_reg < CW'(ENTRIES));
    assign key_raddr   = (state_reg == ST_FETCH) ? victim_reg : cnt_reg[IW-1:0];
    assign key_we      = (state_reg == ST_WRITE) && !hit_found_reg;

    // ways never aged since reset read as zero
    assign age_eff   = age_ok_reg[rd_idx_reg] ? age_rdata : '0;
    assign age_we    = (state_reg == ST_AGE) && rd_pend_reg;
    assign age_wdata = (rd_idx_reg == victim_reg) ? '0 :
                       (age_eff == AGE_MAX) ? AGE_MAX : age_eff + 1'b1;

    assign lfsr_stepped = acr_pkg::lfsr_step(lfsr_reg);
    assign fifo_victim  = ({1'b0, fifo_reg} >= (IW+1)'(ENTRIES)) ? '0 : fifo_reg;
    assign mod_start    = (state_reg == ST_DECIDE) && !hit_found_reg && !pol_fifo
                          && !empty_found_reg && !pol_lru;
    assign out_free     = !out_valid_reg || m_axis_tready;

    acr_ram #(
        .WIDTH(acr_pkg::KEY_W),
        .DEPTH(ENTRIES)
    ) u_key_ram (
        .clk  (clk),
        .we   (key_we),
        .waddr(victim_reg),
        .wdata(key_reg),
        .raddr(key_raddr),
        .rdata(key_rdata)
    );

    acr_ram #(
        .WIDTH(AGE_BITS),
        .DEPTH(ENTRIES)
    ) u_age_ram (
        .clk  (clk),
        .we   (age_we),
        .waddr(rd_idx_reg),
        .wdata(age_wdata),
        .raddr(cnt_reg[IW-1:0]),
        .rdata(age_rdata)
    );

    acr_mod #(
        .DIVISOR(ENTRIES),
        .REM_W  (IW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (lfsr_stepped),
        .done     (mod_done),
        .remainder(mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            rd_pend_reg     <= 1'b0;
            rd_idx_reg      <= '0;
            hit_found_reg   <= 1'b0;
            hit_idx_reg     <= '0;
            empty_found_reg <= 1'b0;
            empty_idx_reg   <= '0;
            best_age_reg    <= '0;
            best_idx_reg    <= '0;
            victim_reg      <= '0;
            fifo_reg        <= '0;
            lfsr_reg        <= acr_pkg::SEED_RESET;
            policy_reg      <= acr_pkg::POL_LRU;
            valid_reg       <= '0;
            age_ok_reg      <= '0;
            ev_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                if (cfg_addr == acr_pkg::REG_POLICY)
                begin
                    policy_reg <= cfg_data[acr_pkg::POLICY_W-1:0];
                end
                else if (cfg_addr == acr_pkg::REG_SEED)
                begin
                    lfsr_reg <= acr_pkg::seed_load(cfg_data);
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        state_reg       <= ST_SCAN;
                        cnt_reg         <= '0;
                        rd_pend_reg     <= 1'b0;
                        hit_found_reg   <= 1'b0;
                        empty_found_reg <= 1'b0;
                        best_age_reg    <= '0;
                        best_idx_reg    <= '0;
                        ev_valid_reg    <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    rd_pend_reg <= sweep_issue;
                    rd_idx_reg  <= cnt_reg[IW-1:0];
                    if (sweep_issue)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (rd_pend_reg)
                    begin
                        if (valid_reg[rd_idx_reg] && key_rdata == key_reg && !hit_found_reg)
                        begin
                            hit_found_reg <= 1'b1;
                            hit_idx_reg   <= rd_idx_reg;
                        end
                        if (!valid_reg[rd_idx_reg] && !empty_found_reg)
                        begin
                            empty_found_reg <= 1'b1;
                            empty_idx_reg   <= rd_idx_reg;
                        end
                        // strictly older wins, so the lowest way keeps ties
                        if (rd_idx_reg == '0 || age_eff > best_age_reg)
                        begin
                            best_age_reg <= age_eff;
                            best_idx_reg <= rd_idx_reg;
                        end
                    end
                    if (!sweep_issue && !rd_pend_reg)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    cnt_reg <= '0;
                    if (hit_found_reg)
                    begin
                        victim_reg <= hit_idx_reg;
                        state_reg  <= pol_lru ? ST_AGE : ST_FINISH;
                    end
                    else if (pol_fifo)
                    begin
                        victim_reg <= fifo_victim;
                        fifo_reg   <= (fifo_victim == IW'(ENTRIES - 1)) ? '0
                                      : fifo_victim + 1'b1;
                        state_reg  <= ST_FETCH;
                    end
                    else if (empty_found_reg)
                    begin
                        victim_reg <= empty_idx_reg;
                        state_reg  <= ST_FETCH;
                    end
                    else if (pol_lru)
                    begin
                        victim_reg <= best_idx_reg;
                        state_reg  <= ST_FETCH;
                    end
                    else
                    begin
                        lfsr_reg  <= lfsr_stepped;
                        state_reg <= ST_MOD;
                    end
                end
                ST_MOD:
                begin
                    if (mod_done)
                    begin
                        victim_reg <= mod_rem;
                        state_reg  <= ST_FETCH;
                    end
                end
                ST_FETCH:
                begin
                    state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    ev_valid_reg          <= valid_reg[victim_reg];
                    valid_reg[victim_reg] <= 1'b1;
                    state_reg             <= pol_lru ? ST_AGE : ST_FINISH;
                end
                ST_AGE:
                begin
                    rd_pend_reg <= sweep_issue;
                    rd_idx_reg  <= cnt_reg[IW-1:0];
                    if (sweep_issue)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (rd_pend_reg)
                    begin
                        age_ok_reg[rd_idx_reg] <= 1'b1;
                    end
                    if (!sweep_issue && !rd_pend_reg)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_axis_tvalid)
        begin
            key_reg <= s_axis_tdata;
        end
        if (state_reg == ST_WRITE)
        begin
            ev_key_reg <= valid_reg[victim_reg] ? key_rdata : '0;
        end
        if (state_reg == ST_FINISH && out_free)
        begin
            out_hit_reg      <= hit_found_reg;
            out_way_reg      <= acr_pkg::WAY_W'(victim_reg);
            out_ev_valid_reg <= !hit_found_reg && ev_valid_reg;
            out_ev_key_reg   <= (!hit_found_reg && ev_valid_reg) ? ev_key_reg : '0;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_ev_key_reg, out_ev_valid_reg, out_way_reg, out_hit_reg};

`ifndef SYNTH
    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> state_reg == ST_SCAN)
        else $error("accepted request did not start the sweep");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_hit_reg |-> !out_ev_valid_reg)
        else $error("hit reported an eviction");

    a_no_evict_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !out_ev_valid_reg |-> out_ev_key_reg == '0)
        else $error("evicted key nonzero without eviction");

    a_mod_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> state_reg == ST_MOD)
        else $error("remainder finished outside its wait state");

    a_way_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> {1'b0, out_way_reg} < (acr_pkg::WAY_W+1)'(ENTRIES))
        else $error("reported way beyond the last entry");
`endif

endmodule

`default_nettype wire

@@ rtl/acr_ram.sv @@
// ----------------------------------------------------------------------------
// acr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/acr_mod.sv @@
// ----------------------------------------------------------------------------
// acr_mod
// Remainder of the lfsr value by a constant, by reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_mod #(
    parameter int DIVISOR = 4,
    parameter int REM_W   = 2
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [acr_pkg::LFSR_W-1:0] dividend,
    output logic                            done,
    output logic      [REM_W-1:0]           remainder
);

    // quotient = (dividend * RECIP) >> SHIFT is exact for every 16-bit dividend
    localparam int SHIFT   = acr_pkg::LFSR_W + $clog2(DIVISOR);
    localparam int RECIP_W = acr_pkg::LFSR_W + 2;
    localparam int PROD_W  = acr_pkg::LFSR_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [PROD_W-1:0]          prod_reg;
    logic [acr_pkg::LFSR_W-1:0] dvd_reg;
    logic [REM_W-1:0]           rem_reg;
    logic                       mul_done_reg;
    logic                       done_reg;
    logic [acr_pkg::LFSR_W-1:0] quot;
    logic [acr_pkg::LFSR_W-1:0] back;
    logic [acr_pkg::LFSR_W-1:0] diff;

    assign quot = acr_pkg::LFSR_W'(prod_reg >> SHIFT);
    assign back = quot * acr_pkg::LFSR_W'(DIVISOR);
    assign diff = dvd_reg - back;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_done_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            mul_done_reg <= start;
            done_reg     <= mul_done_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PROD_W'(dividend) * PROD_W'(RECIP);
            dvd_reg  <= dividend;
        end
        if (mul_done_reg)
        begin
            rem_reg <= diff[REM_W-1:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the associative cache replacement block: drives key
// requests under all replacement policies and several seeds, tracks its own copy of
// the cache contents, ages, fifo pointer and lfsr, and compares every result.
// ----------------------------------------------------------------------------

module tb;

    localparam int NUM_WAYS      = 4;
    localparam int AGE_W         = 8;
    localparam logic [AGE_W-1:0] AGE_TOP = '1;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int NUM_PHASES    = 7;
    localparam int NUM_ROWS      = 28;

    // random replacement: policy 2, and 3 through the high policy bit
    localparam logic [acr_pkg::POLICY_W-1:0] POL_RAND     = 2'd2;
    localparam logic [acr_pkg::POLICY_W-1:0] POL_RAND_ALT = 2'd3;

    // members from the top bit down: evicted_key, evicted_valid, way, hit
    typedef struct packed {
        logic [acr_pkg::KEY_W-1:0] evicted_key;
        logic                      evicted_valid;
        logic [acr_pkg::WAY_W-1:0] way;
        logic                      hit;
    } result_t;

    typedef struct packed {
        logic    used;
        result_t val;
    } typed_exp_t;

    typedef enum logic [0:0] {
        ROW_ACCESS,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t                   kind;
        logic [acr_pkg::CFG_A_W-1:0] reg_idx;
        logic [acr_pkg::CFG_W-1:0]   reg_val;
        logic [acr_pkg::KEY_W-1:0]   key;
        logic                        typed;
        result_t                     want;
    } dir_row_t;

    typedef struct packed {
        logic [acr_pkg::POLICY_W-1:0] pol;
        logic [acr_pkg::CFG_W-1:0]    seed;
        logic [9:0]                   n_items;
        logic [3:0]                   pool_n;
        logic                         fresh;
        logic                         src_idle;
        logic                         sink_idle;
    } phase_t;

    localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
        '{ROW_WRITE,  acr_pkg::REG_POLICY, 16'(acr_pkg::POL_FIFO), 32'h0, 1'b0, '0},
        '{ROW_ACCESS, acr_pkg::REG_POLICY, 16'h0, 32'h00000000, 1'b1,
          '{32'h0, 1'b0, 6'd0, 1'b0}},
        '{ROW_WRITE,  acr_pkg::REG_POLICY, 16'(POL_RAND), 32'h0, 1'b0, '0},
        // random policy still fills the lowest empty way
        '{ROW_ACCESS, acr_pkg::REG_POLICY, 16'h0, 32'hFFFFFFFF, 1'b1,
          '{32'h0, 1'b0, 6'd1, 1'b0}},
        '{ROW_ACCESS, acr_pkg::REG_POLICY, 16'h0, 32'h00000000, 1'b1,
          '{32'h0, 1'b0, 6'd0, 1'b1}},
        '{ROW_WRITE,  acr_pkg::REG_POLICY, 16'(acr_pkg::POL_LRU), 32'h0, 1'b0, '0},
        '{ROW_ACCESS, acr_pkg::REG_POLICY, 16'h0, 32'h5555AAAA, 1'b1,
          '{32'h0, 1'b0, 6'd2, 1'b0}},
        '{ROW_WRITE,  acr_pkg::REG_POLICY, 16'(acr_pkg::POL_FIFO), 32'h0, 1'b0, '0},
        // fifo ignores the empty way and evicts at its pointer
        '{ROW_ACCESS, acr_pkg::REG_POLICY, 16'h0, 32'hAAAA5555, 1'b1,
          '{32'hFFFFFFFF, 1'b1, 6'd1, 1'b0}},
        '{ROW_WRITE,  acr_pkg::REG_POLICY, 16'(acr_pkg::POL_LRU), 32'h0, 1'b0, '0},
        '{ROW_ACCESS, acr_pkg::REG_POLICY, 16'h0, 32'h12345678, 1'b1,
          '{32'h0, 1'b0, 6'd3, 1'b0}},
        '{ROW_ACCESS, acr_pkg::REG_POLICY, 16'h0, 32'h00000001, 1'b0, '0},
        '{ROW_ACCESS, acr_pkg::REG_POLICY, 16'h0, 32'h80000000, 1'b0, '0},
        '{ROW_ACCESS, acr_pkg::REG_POLICY, 16'h0, 32'h5555AAAA, 1'b0, '0},
        '{ROW_WRITE,  acr_pkg::REG_POLICY, 16'(acr_pkg::POL_FIFO), 32'h0, 1'b0, '0},
        '{ROW_ACCESS, acr_pkg::REG_POLICY, 16'h0, 32'h0F0F0F0F, 1'b0, '0},
        '{ROW_ACCESS, acr_pkg::REG_POLICY, 16'h0, 32'hF0F0F0F0, 1'b0, '0},
        // zero seed loads as one
        '{ROW_WRITE,  acr_pkg::REG_SEED,   16'h0000, 32'h0, 1'b0, '0},
        '{ROW_WRITE,  acr_pkg::REG_POLICY, 16'(POL_RAND), 32'h0, 1'b0, '0},
        '{ROW_ACCESS, acr_pkg::REG_POLICY, 16'h0, 32'h13579BDF, 1'b0, '0},
        '{ROW_ACCESS, acr_pkg::REG_POLICY, 16'h0, 32'h2468ACE0, 1'b0, '0},
        '{ROW_WRITE,  acr_pkg::REG_SEED,   16'hFFFF, 32'h0, 1'b0, '0},
        '{ROW_WRITE,  acr_pkg::REG_POLICY, 16'(POL_RAND_ALT), 32'h0, 1'b0, '0},
        '{ROW_ACCESS, acr_pkg::REG_POLICY, 16'h0, 32'h7FFFFFFF, 1'b0, '0},
        '{ROW_ACCESS, acr_pkg::REG_POLICY, 16'h0, 32'hFFFFFFFE, 1'b0, '0},
        '{ROW_WRITE,  acr_pkg::REG_SEED,   acr_pkg::SEED_RESET, 32'h0, 1'b0, '0},
        '{ROW_WRITE,  acr_pkg::REG_POLICY, 16'(acr_pkg::POL_LRU), 32'h0, 1'b0, '0},
        '{ROW_ACCESS, acr_pkg::REG_POLICY, 16'h0, 32'h00000000, 1'b0, '0}
    };

    localparam phase_t PHASES [NUM_PHASES] = '{
        '{acr_pkg::POL_LRU,  16'h0001, 10'd20,  4'd6, 1'b1, 1'b1, 1'b1},
        // two hot keys only: the other ways saturate and tie
        '{acr_pkg::POL_LRU,  16'h1234, 10'd260, 4'd2, 1'b0, 1'b0, 1'b0},
        '{acr_pkg::POL_LRU,  16'h1234, 10'd20,  4'd5, 1'b1, 1'b1, 1'b0},
        '{acr_pkg::POL_FIFO, 16'h8001, 10'd25,  4'd6, 1'b1, 1'b1, 1'b1},
        '{POL_RAND,          16'hFFFF, 10'd30,  4'd6, 1'b1, 1'b0, 1'b1},
        '{POL_RAND_ALT,      16'h8000, 10'd25,  4'd6, 1'b1, 1'b1, 1'b1},
        '{acr_pkg::POL_FIFO, 16'h00FF, 10'd20,  4'd6, 1'b1, 1'b1, 1'b1}
    };

    logic                         clk;
    logic                         rst_n         = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [31:0]                  s_axis_tdata  = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [39:0]                  m_axis_tdata;
    logic                         cfg_we        = 1'b0;
    logic [acr_pkg::CFG_A_W-1:0]  cfg_addr      = '0;
    logic [acr_pkg::CFG_W-1:0]    cfg_data      = '0;

    // shadow of the cache
    logic [acr_pkg::KEY_W-1:0]    line_key   [NUM_WAYS];
    logic                         line_valid [NUM_WAYS];
    logic [AGE_W-1:0]             line_age   [NUM_WAYS];
    int                           fifo_ptr    = 0;
    logic [acr_pkg::LFSR_W-1:0]   lfsr_q      = acr_pkg::SEED_RESET;
    logic [acr_pkg::POLICY_W-1:0] cur_policy  = acr_pkg::POL_LRU;

    result_t                      pending_results [$];
    typed_exp_t                   typed_results_q [$];
    int                           items_sent   = 0;
    int                           results_seen = 0;
    int                           mismatches   = 0;
    int                           idle_cycles  = 0;
    bit                           src_gaps     = 1'b1;
    bit                           sink_gaps    = 1'b1;
    logic [acr_pkg::KEY_W-1:0]    key_pool [8];

    assoc_cache_replacement #(
        .ENTRIES  (NUM_WAYS),
        .AGE_BITS (AGE_W)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            line_key[w]   = '0;
            line_valid[w] = 1'b0;
            line_age[w]   = '0;
        end
    end

    function automatic logic [acr_pkg::LFSR_W-1:0] lfsr_next(
        input logic [acr_pkg::LFSR_W-1:0] v);
        return {1'b0, v[acr_pkg::LFSR_W-1:1]} ^ (v[0] ? acr_pkg::LFSR_TAPS : '0);
    endfunction

    function automatic void touch_ages(input int keep);
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (w == keep)
                line_age[w] = '0;
            else if (line_age[w] != AGE_TOP)
                line_age[w] = line_age[w] + 1'b1;
        end
    endfunction

    function automatic void apply_reg(input logic [acr_pkg::CFG_A_W-1:0] idx,
                                      input logic [acr_pkg::CFG_W-1:0] val);
        if (idx == acr_pkg::REG_POLICY)
            cur_policy = val[acr_pkg::POLICY_W-1:0];
        else if (idx == acr_pkg::REG_SEED)
            lfsr_q = (val == '0) ? 16'd1 : val;
    endfunction

    // lookup, victim choice and fill for one key
    function automatic result_t cache_access(input logic [acr_pkg::KEY_W-1:0] k);
        result_t           r;
        int                victim;
        int                empty_way;
        logic              found;
        logic [AGE_W-1:0]  oldest;
        r = '0;
        found = 1'b0;
        victim = 0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (!found && line_valid[w] && line_key[w] == k)
            begin
                found = 1'b1;
                victim = w;
            end
        end
        if (found)
        begin
            if (cur_policy == acr_pkg::POL_LRU)
                touch_ages(victim);
            r.hit = 1'b1;
            r.way = acr_pkg::WAY_W'(victim);
            return r;
        end
        if (cur_policy == acr_pkg::POL_FIFO)
        begin
            victim = fifo_ptr;
            fifo_ptr = (fifo_ptr + 1) % NUM_WAYS;
        end
        else
        begin
            empty_way = -1;
            for (int w = NUM_WAYS - 1; w >= 0; w--)
            begin
                if (!line_valid[w])
                    empty_way = w;
            end
            if (empty_way >= 0)
                victim = empty_way;
            else if (cur_policy == acr_pkg::POL_LRU)
            begin
                oldest = line_age[0];
                for (int w = 1; w < NUM_WAYS; w++)
                begin
                    if (line_age[w] > oldest)
                    begin
                        oldest = line_age[w];
                        victim = w;
                    end
                end
            end
            else
            begin
                lfsr_q = lfsr_next(lfsr_q);
                victim = int'(lfsr_q) % NUM_WAYS;
            end
        end
        r.way = acr_pkg::WAY_W'(victim);
        if (line_valid[victim])
        begin
            r.evicted_valid = 1'b1;
            r.evicted_key = line_key[victim];
        end
        line_key[victim] = k;
        line_valid[victim] = 1'b1;
        if (cur_policy == acr_pkg::POL_LRU)
            touch_ages(victim);
        return r;
    endfunction

    // predicts on each accepted request, checks each accepted result
    always @(posedge clk)
    begin : monitor
        result_t    want;
        result_t    got;
        typed_exp_t t;
        bit         moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_we)
                apply_reg(cfg_addr, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = cache_access(s_axis_tdata);
                if (typed_results_q.size() != 0)
                begin
                    t = typed_results_q.pop_front();
                    if (t.used)
                        want = t.val;
                end
                pending_results.push_back(want);
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata);
                if (pending_results.size() == 0)
                begin
                    $error("result with no request outstanding: %h", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, got.hit);
                        mismatches++;
                    end
                    if (got.way !== want.way)
                    begin
                        $error("way: expected %0d, got %0d", want.way, got.way);
                        mismatches++;
                    end
                    if (got.evicted_valid !== want.evicted_valid)
                    begin
                        $error("evicted_valid: expected %0d, got %0d",
                               want.evicted_valid, got.evicted_valid);
                        mismatches++;
                    end
                    if (got.evicted_key !== want.evicted_key)
                    begin
                        $error("evicted_key: expected %h, got %h",
                               want.evicted_key, got.evicted_key);
                        mismatches++;
                    end
                end
                results_seen++;
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // result side: random stalls per result while sink_gaps is set
    initial
    begin : sink
        int gap;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = sink_gaps ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_key(input logic [acr_pkg::KEY_W-1:0] k, input logic known,
                            input result_t known_val);
        int         gap;
        typed_exp_t t;
        gap = src_gaps ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        t.used = known;
        t.val = known_val;
        typed_results_q.push_back(t);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= k;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [acr_pkg::CFG_A_W-1:0] idx,
                             input logic [acr_pkg::CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        phase_t                    ph;
        logic [acr_pkg::KEY_W-1:0] k;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (DIR_ROWS[r].kind == ROW_WRITE)
            begin
                wait_for_results();
                write_reg(DIR_ROWS[r].reg_idx, DIR_ROWS[r].reg_val);
            end
            else
                send_key(DIR_ROWS[r].key, DIR_ROWS[r].typed, DIR_ROWS[r].want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            ph = PHASES[p];
            wait_for_results();
            src_gaps = ph.src_idle;
            sink_gaps = ph.sink_idle;
            write_reg(acr_pkg::REG_POLICY, acr_pkg::CFG_W'(ph.pol));
            write_reg(acr_pkg::REG_SEED, ph.seed);
            for (int i = 0; i < 8; i++)
                key_pool[i] = $urandom();
            for (int n = 0; n < ph.n_items; n++)
            begin
                if (ph.fresh && $urandom_range(0, 7) == 0)
                    k = $urandom();
                else
                    k = key_pool[$urandom_range(0, ph.pool_n - 1)];
                send_key(k, 1'b0, '0);
                // occasionally let the pipe run dry
                if ($urandom_range(0, 49) == 0)
                    wait_for_results();
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
